// ===== rtl/core/idts_pkg.sv =====
// Shared types and constants for the indentation token scanner.
`default_nettype none

package idts_pkg;

    localparam int CH_W    = 21;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int TAB_INC = 8;

    localparam logic [CH_W-1:0] CH_NUL   = 21'h000000;
    localparam logic [CH_W-1:0] CH_TAB   = 21'h000009;
    localparam logic [CH_W-1:0] CH_LF    = 21'h00000A;
    localparam logic [CH_W-1:0] CH_FF    = 21'h00000C;
    localparam logic [CH_W-1:0] CH_CR    = 21'h00000D;
    localparam logic [CH_W-1:0] CH_SPACE = 21'h000020;
    localparam logic [CH_W-1:0] CH_HASH  = 21'h000023;
    localparam logic [CH_W-1:0] CH_DASH  = 21'h00002D;
    localparam logic [CH_W-1:0] CH_DOT   = 21'h00002E;
    localparam logic [CH_W-1:0] CH_SLASH = 21'h00002F;
    localparam logic [CH_W-1:0] CH_0     = 21'h000030;
    localparam logic [CH_W-1:0] CH_9     = 21'h000039;
    localparam logic [CH_W-1:0] CH_UA    = 21'h000041;
    localparam logic [CH_W-1:0] CH_UZ    = 21'h00005A;
    localparam logic [CH_W-1:0] CH_LA    = 21'h000061;
    localparam logic [CH_W-1:0] CH_LZ    = 21'h00007A;

    // Character class decided in the front part; end of file is a class of its own.
    typedef enum logic [3:0] {
        CL_OTHER,
        CL_SPACE,
        CL_TAB,
        CL_CRFF,
        CL_LF,
        CL_HASH,
        CL_SLASH,
        CL_RUN,
        CL_NUL,
        CL_EOF
    } cls_t;

    typedef struct packed {
        logic recover;
        logic path;
        logic dedent;
        logic indent;
        logic newline;
    } flags_t;

    typedef struct packed {
        cls_t   cls;
        logic   scan_start;
        flags_t flags;
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BLANK,
        PH_COMMENT,
        PH_PATH
    } phase_t;

    typedef enum logic [2:0] {
        TK_SCAN,
        TK_NEWLINE,
        TK_INDENT,
        TK_DEDENT,
        TK_PATH,
        TK_NONE
    } tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/idts_front.sv =====
// Front part: accepts characters and classifies them into queue requests.
`default_nettype none

module idts_front
    import idts_pkg::*;
(
    input  wire logic            char_valid,
    output logic                 char_stall,
    input  wire logic [CH_W-1:0] ch,
    input  wire logic            at_eof,
    input  wire logic            scan_start,
    input  wire logic            newline_ok,
    input  wire logic            indent_ok,
    input  wire logic            dedent_ok,
    input  wire logic            path_ok,
    input  wire logic            recovering,
    input  wire logic            q_full,
    output logic                 q_push,
    output req_t                 q_data
);

    cls_t cls;

    // Classify the lookahead; end of file overrides the character.
    always_comb
    begin
        if (at_eof)
        begin
            cls = CL_EOF;
        end
        else if (ch == CH_SPACE)
        begin
            cls = CL_SPACE;
        end
        else if (ch == CH_TAB)
        begin
            cls = CL_TAB;
        end
        else if (ch == CH_CR || ch == CH_FF)
        begin
            cls = CL_CRFF;
        end
        else if (ch == CH_LF)
        begin
            cls = CL_LF;
        end
        else if (ch == CH_HASH)
        begin
            cls = CL_HASH;
        end
        else if (ch == CH_SLASH)
        begin
            cls = CL_SLASH;
        end
        else if (ch == CH_NUL)
        begin
            cls = CL_NUL;
        end
        else if (ch inside {[CH_0:CH_9], [CH_UA:CH_UZ], [CH_LA:CH_LZ], CH_DOT, CH_DASH})
        begin
            cls = CL_RUN;
        end
        else
        begin
            cls = CL_OTHER;
        end
    end

    assign char_stall = q_full;
    assign q_push     = char_valid && !q_full;

    always_comb
    begin
        q_data.cls            = cls;
        q_data.scan_start     = scan_start;
        q_data.flags.newline  = newline_ok;
        q_data.flags.indent   = indent_ok;
        q_data.flags.dedent   = dedent_ok;
        q_data.flags.path     = path_ok;
        q_data.flags.recover  = recovering;
    end

endmodule

`default_nettype wire

// ===== rtl/core/idts_queue.sv =====
// Short request queue between the front and back parts.
`default_nettype none

module idts_queue
    import idts_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  req_t      push_data,
    output logic      full,
    output logic      pop_valid,
    input  wire logic pop,
    output req_t      pop_data
);

    req_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_pop    = pop && pop_valid;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/idts_back.sv =====
// Back part: scan state, indent stack and the registered result.
`default_nettype none

module idts_back
    import idts_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int INDENT_WIDTH = 16,
    parameter int CNT_W        = $clog2(STACK_DEPTH + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  req_t                   q_data,
    output logic                   tok_valid,
    input  wire logic              tok_stall,
    output logic [2:0]             token,
    output logic                   consumed,
    output logic                   stack_full,
    output logic [CNT_W-1:0]       nesting_depth
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [INDENT_WIDTH-1:0] IND_MAX = '1;

    // Stack entries below the top live in memory; the top is a register.
    logic [INDENT_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [INDENT_WIDTH-1:0] rd_data_reg;
    logic [INDENT_WIDTH-1:0] byp_data_reg;
    logic                    byp_reg;
    logic [INDENT_WIDTH-1:0] below;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [CNT_W-1:0]        cnt_m1;
    logic [CNT_W-1:0]        cnt_next_m2;

    phase_t                  phase_reg, phase_next;
    flags_t                  flags_reg, flags_next;
    logic                    le_reg, le_next;
    logic [INDENT_WIDTH-1:0] ind_reg, ind_next;
    logic                    cs_reg, cs_next;
    logic [INDENT_WIDTH-1:0] ci_reg, ci_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [INDENT_WIDTH-1:0] top_reg, top_next;

    logic                    out_valid_reg, out_valid_next;
    tok_t                    tok_reg, tok_next;
    logic                    cons_reg, cons_next;
    logic                    full_reg, full_next;
    logic [CNT_W-1:0]        depth_reg, depth_next;

    // Values after the scan-start step, before the character acts.
    phase_t                  ph_s;
    flags_t                  fl_s;
    logic                    le_s;
    logic [INDENT_WIDTH-1:0] ind_s;
    logic                    cs_s;
    logic [INDENT_WIDTH-1:0] ci_s;

    cls_t                    cls;
    logic                    step;
    logic                    hash_cmt;
    logic                    blank_other;
    logic                    do_dec;
    logic                    dec_le;
    logic [INDENT_WIDTH-1:0] dec_ind;
    logic                    want_ind;
    logic                    want_ded;
    logic                    want_nl;
    logic                    want_run;
    logic                    stk_full;
    logic                    do_push;
    logic                    do_pop;
    logic [INDENT_WIDTH:0]   sum1;
    logic [INDENT_WIDTH:0]   sum8;
    logic [INDENT_WIDTH-1:0] ind_p1;
    logic [INDENT_WIDTH-1:0] ind_p8;

    assign cls   = q_data.cls;
    assign step  = q_valid && (!out_valid_reg || !tok_stall);
    assign q_pop = step;

    always_comb
    begin
        if (q_data.scan_start)
        begin
            fl_s  = q_data.flags;
            le_s  = 1'b0;
            ind_s = '0;
            cs_s  = 1'b0;
            ci_s  = '0;
            ph_s  = q_data.flags.recover ? PH_IDLE : PH_BLANK;
        end
        else
        begin
            fl_s  = flags_reg;
            le_s  = le_reg;
            ind_s = ind_reg;
            cs_s  = cs_reg;
            ci_s  = ci_reg;
            ph_s  = phase_reg;
        end
    end

    assign sum1   = {1'b0, ind_s} + (INDENT_WIDTH + 1)'(1);
    assign sum8   = {1'b0, ind_s} + (INDENT_WIDTH + 1)'(TAB_INC);
    assign ind_p1 = sum1[INDENT_WIDTH] ? IND_MAX : sum1[INDENT_WIDTH-1:0];
    assign ind_p8 = sum8[INDENT_WIDTH] ? IND_MAX : sum8[INDENT_WIDTH-1:0];

    assign below    = byp_reg ? byp_data_reg : rd_data_reg;
    assign stk_full = (count_reg == CNT_W'(STACK_DEPTH));

    // Decision terms shared by the next-state and output logic.
    assign hash_cmt    = (cls == CL_HASH) && (fl_s.newline || fl_s.indent || fl_s.dedent);
    assign blank_other = !(cls inside {CL_EOF, CL_LF, CL_SPACE, CL_CRFF, CL_TAB}) && !hash_cmt;
    assign do_dec      = ((ph_s == PH_COMMENT) && (cls == CL_EOF)) ||
                         ((ph_s == PH_BLANK) && ((cls == CL_EOF) || blank_other));
    assign dec_le      = (cls == CL_EOF) || le_s;
    assign dec_ind     = (cls == CL_EOF) ? '0 : ind_s;
    assign want_ind    = dec_le && fl_s.indent && (dec_ind > top_reg);
    assign want_ded    = dec_le && !want_ind && (fl_s.dedent || !fl_s.newline) &&
                         (dec_ind < top_reg) && (!cs_s || (ci_s < top_reg)) &&
                         (count_reg > CNT_W'(1));
    assign want_nl     = dec_le && !want_ind && !want_ded && fl_s.newline;
    assign want_run    = !want_ind && !want_ded && !want_nl && fl_s.path && (cls == CL_RUN);
    assign do_push     = step && do_dec && want_ind && !stk_full;
    assign do_pop      = step && do_dec && want_ded;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (ph_s)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_BLANK:
                begin
                    if (do_dec)
                    begin
                        phase_next = want_run ? PH_PATH : PH_IDLE;
                    end
                    else if (hash_cmt)
                    begin
                        phase_next = le_s ? PH_COMMENT : PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_BLANK;
                    end
                end
                PH_COMMENT:
                begin
                    if (do_dec)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (cls == CL_LF || cls == CL_NUL)
                    begin
                        phase_next = PH_BLANK;
                    end
                    else
                    begin
                        phase_next = PH_COMMENT;
                    end
                end
                PH_PATH:
                begin
                    phase_next = (cls == CL_RUN) ? PH_PATH : PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Datapath and result.
    always_comb
    begin
        flags_next     = flags_reg;
        le_next        = le_reg;
        ind_next       = ind_reg;
        cs_next        = cs_reg;
        ci_next        = ci_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && tok_stall;
        tok_next       = tok_reg;
        cons_next      = cons_reg;
        full_next      = full_reg;
        depth_next     = depth_reg;
        if (step)
        begin
            flags_next = fl_s;
            le_next    = le_s;
            ind_next   = ind_s;
            cs_next    = cs_s;
            ci_next    = ci_s;
            tok_next   = (ph_s == PH_IDLE) ? TK_NONE : TK_SCAN;
            cons_next  = 1'b0;
            full_next  = 1'b0;
            case (ph_s)
                PH_BLANK:
                begin
                    case (cls)
                        CL_EOF, CL_LF:
                        begin
                            ind_next = '0;
                            le_next  = 1'b1;
                        end
                        CL_SPACE:
                        begin
                            ind_next = ind_p1;
                        end
                        CL_TAB:
                        begin
                            ind_next = ind_p8;
                        end
                        CL_CRFF:
                        begin
                            ind_next = '0;
                        end
                        default:
                        begin
                            if (hash_cmt)
                            begin
                                if (!le_s)
                                begin
                                    tok_next = TK_NONE;
                                end
                                else if (!cs_s)
                                begin
                                    cs_next = 1'b1;
                                    ci_next = ind_s;
                                end
                            end
                        end
                    endcase
                end
                PH_COMMENT:
                begin
                    if (cls == CL_EOF)
                    begin
                        ind_next = '0;
                        le_next  = 1'b1;
                    end
                    else if (cls == CL_LF || cls == CL_NUL)
                    begin
                        ind_next = '0;
                    end
                end
                PH_PATH:
                begin
                    if (cls == CL_RUN)
                    begin
                        cons_next = 1'b1;
                    end
                    else if (cls == CL_SLASH)
                    begin
                        tok_next = TK_PATH;
                    end
                    else
                    begin
                        tok_next = TK_NONE;
                    end
                end
                default:
                begin
                end
            endcase

            if (do_dec)
            begin
                if (want_ind)
                begin
                    tok_next  = TK_INDENT;
                    full_next = stk_full;
                end
                else if (want_ded)
                begin
                    tok_next = TK_DEDENT;
                end
                else if (want_nl)
                begin
                    tok_next = TK_NEWLINE;
                end
                else if (want_run)
                begin
                    tok_next  = TK_SCAN;
                    cons_next = 1'b1;
                end
                else
                begin
                    tok_next = TK_NONE;
                end
            end

            if (do_push)
            begin
                count_next = count_reg + 1'b1;
                top_next   = dec_ind;
            end
            else if (do_pop)
            begin
                count_next = count_reg - 1'b1;
                top_next   = below;
            end

            depth_next     = count_next - 1'b1;
            out_valid_next = 1'b1;
        end
    end

    // Stack memory: write the old top on a push, read the entry under the next top.
    assign cnt_m1      = count_reg - 1'b1;
    assign cnt_next_m2 = count_next - CNT_W'(2);
    assign wr_idx      = cnt_m1[IDX_W-1:0];
    assign rd_idx      = cnt_next_m2[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[wr_idx] <= top_reg;
        end
        rd_data_reg  <= stack_mem[rd_idx];
        byp_data_reg <= top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            flags_reg     <= '0;
            le_reg        <= 1'b0;
            ind_reg       <= '0;
            cs_reg        <= 1'b0;
            ci_reg        <= '0;
            count_reg     <= CNT_W'(1);
            top_reg       <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            le_reg        <= le_next;
            ind_reg       <= ind_next;
            cs_reg        <= cs_next;
            ci_reg        <= ci_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            byp_reg       <= do_push;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg   <= tok_next;
        cons_reg  <= cons_next;
        full_reg  <= full_next;
        depth_reg <= depth_next;
    end

    assign tok_valid     = out_valid_reg;
    assign token         = tok_reg;
    assign consumed      = cons_reg;
    assign stack_full    = full_reg;
    assign nesting_depth = depth_reg;

endmodule

`default_nettype wire

// ===== rtl/core/indent_dedent_token_scanner.sv =====
// Top level of the indentation token scanner: front, request queue and back.
//
// One character request enters per cycle on the char channel while the queue
// has room, and one token result leaves per cycle on the tok channel while
// tok_stall is low. The front part classifies the character (blank, line
// break, comment mark, path character, slash, end of file) in the accepting
// cycle and writes it into a four-entry queue; the back part takes one request
// per cycle from the queue unless a held result stalls, advances the scan,
// updates the indent stack and loads the result register. Every request gives
// exactly one result, loaded when the back part takes the request from the
// queue. The sustained rate is one request per cycle while the tok channel
// does not stall, set by the back part's step (compares against the stack
// top, one push or pop). The top of the indent stack is held in a register
// and the entries below it in a STACK_DEPTH-entry memory whose registered read
// prefetches the entry under the top, with a bypass register after a push, so
// back-to-back pops need no bubble. The memory needs no clearing pass: an
// entry is always written by a push before it can be read. char_stall rises
// when the queue is full; tok_valid holds until the result is taken. The
// acceptance flags are latched on a request with scan_start set and govern
// the whole scan. nesting_depth is the number of indent levels above the base.
`default_nettype none

module indent_dedent_token_scanner
    import idts_pkg::*;
#(
    parameter int STACK_DEPTH  = 64,
    parameter int INDENT_WIDTH = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                char_valid,
    output logic                                     char_stall,
    input  wire logic [20:0]                         ch,
    input  wire logic                                at_eof,
    input  wire logic                                scan_start,
    input  wire logic                                newline_ok,
    input  wire logic                                indent_ok,
    input  wire logic                                dedent_ok,
    input  wire logic                                path_ok,
    input  wire logic                                recovering,
    output logic                                     tok_valid,
    input  wire logic                                tok_stall,
    output logic [2:0]                               token,
    output logic                                     consumed,
    output logic                                     stack_full,
    output logic [$clog2(STACK_DEPTH + 1)-1:0]       nesting_depth
);

    logic q_full;
    logic q_push;
    req_t q_wdata;
    logic q_valid;
    logic q_pop;
    req_t q_rdata;

    // Classify and accept.
    idts_front u_front
    (
        .char_valid (char_valid),
        .char_stall (char_stall),
        .ch         (ch),
        .at_eof     (at_eof),
        .scan_start (scan_start),
        .newline_ok (newline_ok),
        .indent_ok  (indent_ok),
        .dedent_ok  (dedent_ok),
        .path_ok    (path_ok),
        .recovering (recovering),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // Hold requests so front and back stall independently.
    idts_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_rdata)
    );

    // Advance the scan and the stack, register the token.
    idts_back #(
        .STACK_DEPTH  (STACK_DEPTH),
        .INDENT_WIDTH (INDENT_WIDTH),
        .CNT_W        ($clog2(STACK_DEPTH + 1))
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_rdata),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .token         (token),
        .consumed      (consumed),
        .stack_full    (stack_full),
        .nesting_depth (nesting_depth)
    );

endmodule

`default_nettype wire

// ===== tb/indent_dedent_token_scanner_test.sv =====
// Self-checking testbench for the indentation token scanner, with its own scan predictor.
module indent_dedent_token_scanner_test;
    import idts_pkg::*;

    localparam int STK_N       = 64;
    localparam int IND_W       = 16;
    localparam int DEPTH_W     = $clog2(STK_N + 1);
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int MAX_GAP     = 40;
    localparam logic [CH_W-1:0] CH_TOP = 21'h10FFFF;

    // One expected token result, in the order the block must return them.
    typedef struct packed {
        tok_t               tk;
        logic               cons;
        logic               full;
        logic [DEPTH_W-1:0] lvl;
    } tok_result_t;

    // Scan predictor plus the queue of token results still owed by the block.
    class token_tracker;
        logic [IND_W-1:0] levels [STK_N];
        int               depth_cnt;
        phase_t           phase;
        bit               line_end;
        logic [IND_W-1:0] indent;
        bit               cmt_seen;
        logic [IND_W-1:0] cmt_indent;
        flags_t           lflags;
        tok_result_t      owed_tokens [$];
        int               errors;
        int               results_seen;

        function new();
            foreach (levels[i]) levels[i] = '0;
            depth_cnt    = 1;
            phase        = PH_IDLE;
            line_end     = 1'b0;
            indent       = '0;
            cmt_seen     = 1'b0;
            cmt_indent   = '0;
            lflags       = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function logic [IND_W-1:0] top_level();
            return levels[(depth_cnt - 1) % STK_N];
        endfunction

        function int pending();
            return owed_tokens.size();
        endfunction

        function bit is_path_char(logic [CH_W-1:0] c);
            return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LZ) ||
                   (c >= CH_UA && c <= CH_UZ) || c == CH_DOT || c == CH_DASH;
        endfunction

        // Add blanks to the indent, clamping at the widest count.
        function void add_blank(int n);
            logic [IND_W:0] sum;
            sum    = {1'b0, indent} + n;
            indent = sum[IND_W] ? {IND_W{1'b1}} : sum[IND_W-1:0];
        endfunction

        // Decide the token at the first significant character or at end of file.
        function void settle(input logic [CH_W-1:0] c, input bit eof,
                             inout tok_t tk, inout bit cons, inout bit full);
            logic [IND_W-1:0] top;
            phase = PH_IDLE;
            if (line_end) begin
                top = top_level();
                if (lflags.indent && indent > top) begin
                    if (depth_cnt < STK_N) begin
                        levels[depth_cnt] = indent;
                        depth_cnt++;
                    end else begin
                        full = 1'b1;
                    end
                    tk = TK_INDENT;
                    return;
                end
                if ((lflags.dedent || !lflags.newline) && indent < top &&
                    (!cmt_seen || cmt_indent < top) && depth_cnt > 1) begin
                    depth_cnt--;
                    tk = TK_DEDENT;
                    return;
                end
                if (lflags.newline) begin
                    tk = TK_NEWLINE;
                    return;
                end
            end
            if (lflags.path && !eof && is_path_char(c)) begin
                phase = PH_PATH;
                cons  = 1'b1;
                tk    = TK_SCAN;
                return;
            end
            tk = TK_NONE;
        endfunction

        // Advance the scan by one accepted request and queue the token it owes.
        function void note_char(logic [CH_W-1:0] c, bit eof, bit start, flags_t fl);
            tok_t        tk;
            bit          cons;
            bit          full;
            tok_result_t owed;
            tk   = TK_SCAN;
            cons = 1'b0;
            full = 1'b0;
            if (start) begin
                lflags     = fl;
                line_end   = 1'b0;
                indent     = '0;
                cmt_seen   = 1'b0;
                cmt_indent = '0;
                phase      = fl.recover ? PH_IDLE : PH_BLANK;
                if (fl.recover)
                    tk = TK_NONE;
            end else if (phase == PH_IDLE) begin
                tk = TK_NONE;
            end
            case (phase)
                PH_COMMENT:
                    if (eof) begin
                        indent   = '0;
                        line_end = 1'b1;
                        settle(c, eof, tk, cons, full);
                    end else if (c == CH_LF || c == CH_NUL) begin
                        indent = '0;
                        phase  = PH_BLANK;
                    end
                PH_BLANK:
                    if (eof) begin
                        indent   = '0;
                        line_end = 1'b1;
                        settle(c, eof, tk, cons, full);
                    end else if (c == CH_LF) begin
                        line_end = 1'b1;
                        indent   = '0;
                    end else if (c == CH_SPACE) begin
                        add_blank(1);
                    end else if (c == CH_CR || c == CH_FF) begin
                        indent = '0;
                    end else if (c == CH_TAB) begin
                        add_blank(TAB_INC);
                    end else if (c == CH_HASH &&
                                 (lflags.newline || lflags.indent || lflags.dedent)) begin
                        if (!line_end) begin
                            tk    = TK_NONE;
                            phase = PH_IDLE;
                        end else begin
                            if (!cmt_seen) begin
                                cmt_seen   = 1'b1;
                                cmt_indent = indent;
                            end
                            phase = PH_COMMENT;
                        end
                    end else begin
                        settle(c, eof, tk, cons, full);
                    end
                PH_PATH: begin
                    phase = PH_IDLE;
                    if (!eof && is_path_char(c)) begin
                        cons  = 1'b1;
                        phase = PH_PATH;
                    end else if (!eof && c == CH_SLASH) begin
                        tk = TK_PATH;
                    end else begin
                        tk = TK_NONE;
                    end
                end
                default: ;
            endcase
            owed.tk   = tk;
            owed.cons = cons;
            owed.full = full;
            owed.lvl  = DEPTH_W'(depth_cnt - 1);
            owed_tokens.push_back(owed);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 200)
                $display("mismatch at token %0d: %s got %0h want %0h",
                         results_seen, what, got, want);
        endtask

        // Compare one accepted token result with the oldest one owed.
        task check_token(logic [2:0] tk, logic cons, logic full, logic [DEPTH_W-1:0] lvl);
            tok_result_t want;
            results_seen++;
            if (owed_tokens.size() == 0) begin
                report_mismatch("token with none owed, token", 32'(tk), '0);
                return;
            end
            want = owed_tokens.pop_front();
            if (tk !== 3'(want.tk))
                report_mismatch("token", 32'(tk), 32'(want.tk));
            if (cons !== want.cons)
                report_mismatch("consumed", 32'(cons), 32'(want.cons));
            if (full !== want.full)
                report_mismatch("stack_full", 32'(full), 32'(want.full));
            if (lvl !== want.lvl)
                report_mismatch("nesting_depth", 32'(lvl), 32'(want.lvl));
        endtask
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               char_valid   = 1'b0;
    logic               char_stall;
    logic [CH_W-1:0]    ch           = '0;
    logic               at_eof       = 1'b0;
    logic               scan_start   = 1'b0;
    logic               newline_ok   = 1'b0;
    logic               indent_ok    = 1'b0;
    logic               dedent_ok    = 1'b0;
    logic               path_ok      = 1'b0;
    logic               recovering   = 1'b0;
    logic               tok_valid;
    logic               tok_stall    = 1'b0;
    logic [2:0]         token;
    logic               consumed;
    logic               stack_full;
    logic [DEPTH_W-1:0] nesting_depth;

    token_tracker sb;

    // Traffic shaping, set by the main sequence and read by the drivers.
    int     send_pct     = 0;
    int     recv_pct     = 0;
    int     hold_trigger = 0;
    int     hold_seen    = 0;
    int     hold_left    = 0;
    int     accepted_n   = 0;
    int     quiet_run    = 0;
    bit     scan_pending = 1'b0;
    flags_t scan_flags   = '0;

    indent_dedent_token_scanner #(
        .STACK_DEPTH  (STK_N),
        .INDENT_WIDTH (IND_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .ch            (ch),
        .at_eof        (at_eof),
        .scan_start    (scan_start),
        .newline_ok    (newline_ok),
        .indent_ok     (indent_ok),
        .dedent_ok     (dedent_ok),
        .path_ok       (path_ok),
        .recovering    (recovering),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .token         (token),
        .consumed      (consumed),
        .stack_full    (stack_full),
        .nesting_depth (nesting_depth)
    );

    always #5 clk = ~clk;

    // Token receiver: hold off for a long stretch when asked, else stall at random.
    always @(posedge clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            tok_stall <= 1'b1;
        end else begin
            tok_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // Monitor both channels at the edge; check results before noting the new request
    // so a result can never be matched against a request of the same cycle.
    always @(posedge clk) begin
        if (rst_n) begin
            if (tok_valid && !tok_stall)
                sb.check_token(token, consumed, stack_full, nesting_depth);
            if (char_valid && !char_stall) begin
                sb.note_char(ch, at_eof, scan_start,
                             flags_t'({recovering, path_ok, dedent_ok, indent_ok, newline_ok}));
                accepted_n++;
            end
            // Watchdog: end the run when neither channel moves for too long.
            if ((char_valid && !char_stall) || (tok_valid && !tok_stall))
                quiet_run = 0;
            else
                quiet_run++;
            if (quiet_run >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Arm the next request to open a scan with the given acceptance flags.
    task automatic open_scan(flags_t f);
        scan_pending = 1'b1;
        scan_flags   = f;
    endtask

    // Drive one request: insert a random idle gap, present it, hold it until accepted.
    task automatic drive_req(logic [CH_W-1:0] c, bit eof);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        ch         <= eof ? CH_W'($urandom_range(0, 1114111)) : c;
        at_eof     <= eof;
        scan_start <= scan_pending;
        if (scan_pending) begin
            newline_ok <= scan_flags.newline;
            indent_ok  <= scan_flags.indent;
            dedent_ok  <= scan_flags.dedent;
            path_ok    <= scan_flags.path;
            recovering <= scan_flags.recover;
        end else begin
            // Flags are ignored outside a scan opening; toggle them anyway.
            newline_ok <= $urandom_range(1);
            indent_ok  <= $urandom_range(1);
            dedent_ok  <= $urandom_range(1);
            path_ok    <= $urandom_range(1);
            recovering <= $urandom_range(1);
        end
        scan_pending = 1'b0;
        do
            @(posedge clk);
        while (!(char_valid && !char_stall));
    endtask

    task automatic send_char(logic [CH_W-1:0] c);
        drive_req(c, 1'b0);
    endtask

    task automatic send_eof();
        drive_req('0, 1'b1);
    endtask

    // Emit an indent of n columns as tabs and then spaces.
    task automatic send_indent(int n);
        repeat (n / TAB_INC) send_char(CH_TAB);
        repeat (n % TAB_INC) send_char(CH_SPACE);
    endtask

    // Drop the request valid and wait until every owed token has come back.
    task automatic wait_drained();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic flags_t rand_flags();
        flags_t f;
        f.newline = $urandom_range(1);
        f.indent  = $urandom_range(1);
        f.dedent  = $urandom_range(1);
        f.path    = $urandom_range(1);
        f.recover = ($urandom_range(15) == 0);
        return f;
    endfunction

    function automatic logic [CH_W-1:0] pick_run();
        case ($urandom_range(4))
            0:       return CH_0 + CH_W'($urandom_range(9));
            1:       return CH_LA + CH_W'($urandom_range(25));
            2:       return CH_UA + CH_W'($urandom_range(25));
            3:       return CH_DOT;
            default: return CH_DASH;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] pick_any();
        if ($urandom_range(1))
            return CH_W'($urandom_range(0, 127));
        return CH_W'($urandom_range(0, 1114111));
    endfunction

    function automatic logic [CH_W-1:0] pick_blank();
        case ($urandom_range(3))
            0:       return CH_TAB;
            1:       return CH_CR;
            2:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    // One well-formed line scan: optional blanks, line breaks, comment lines, an indent
    // chosen against the stack top, then a deciding character and a path-like tail.
    task automatic line_scan();
        flags_t f;
        int     top;
        int     n;
        int     sel;
        f = rand_flags();
        open_scan(f);
        repeat ($urandom_range(0, 2)) send_char(pick_blank());
        if ($urandom_range(9) == 0) begin
            // Trailing comment: a hash before any line break.
            send_char(CH_HASH);
            return;
        end
        if ($urandom_range(9) != 0) begin
            send_char(CH_LF);
            repeat ($urandom_range(0, 1)) send_char(CH_LF);
            if ($urandom_range(2) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    top = int'(sb.top_level());
                    send_indent($urandom_range(1) ? top : $urandom_range(0, top + 4));
                    send_char(CH_HASH);
                    repeat ($urandom_range(0, 3)) send_char(pick_any());
                    if ($urandom_range(19) == 0) begin
                        send_eof();
                        return;
                    end
                    // Abandon mid-comment; the next scan restarts.
                    if ($urandom_range(19) == 0)
                        return;
                    send_char($urandom_range(4) == 0 ? CH_NUL : CH_LF);
                end
            end
            top = int'(sb.top_level());
            sel = $urandom_range(9);
            if (sel < 4)
                n = top + $urandom_range(1, 12);
            else if (sel < 6)
                n = top;
            else if (sel < 9)
                n = (top == 0) ? 0 : $urandom_range(0, top - 1);
            else
                n = 0;
            if ($urandom_range(15) == 0) begin
                send_indent(3);
                send_char(CH_CR);
            end
            send_indent(n);
        end
        sel = $urandom_range(15);
        if (sel < 2) begin
            send_eof();
            return;
        end
        send_char(sel < 12 ? pick_run() : pick_any());
        repeat ($urandom_range(0, 3)) send_char(pick_run());
        send_char($urandom_range(3) != 0 ? CH_SLASH : pick_any());
    endtask

    // A scan aimed at the path rule: a run that mostly ends in a slash.
    task automatic path_scan();
        flags_t f;
        int     sel;
        f         = rand_flags();
        f.path    = 1'b1;
        f.recover = ($urandom_range(31) == 0);
        open_scan(f);
        repeat ($urandom_range(0, 2)) send_char(CH_SPACE);
        repeat ($urandom_range(1, 6)) send_char(pick_run());
        sel = $urandom_range(7);
        if (sel < 6)
            send_char(CH_SLASH);
        else if (sel == 6)
            send_eof();
        else
            send_char(pick_any());
    endtask

    // Fully random requests: random openings, flags, code points and end of file.
    task automatic noise_burst();
        flags_t f;
        repeat ($urandom_range(1, 4)) begin
            f           = rand_flags();
            f.recover   = $urandom_range(1);
            scan_flags  = f;
            scan_pending = ($urandom_range(3) == 0);
            drive_req(pick_any(), $urandom_range(15) == 0);
        end
    endtask

    task automatic random_traffic(int count);
        int target;
        int sel;
        target = accepted_n + count;
        while (accepted_n < target) begin
            sel = $urandom_range(19);
            if (sel < 14)
                line_scan();
            else if (sel < 17)
                path_scan();
            else
                noise_burst();
        end
    endtask

    // Open a scan that pushes one level above the current top.
    task automatic push_level(int extra);
        open_scan(flags_t'(5'b00010));
        send_char(CH_LF);
        send_indent(int'(sb.top_level()) + extra);
        send_char(CH_LA);
    endtask

    // End of file decides at indent zero, so each such scan pops one level.
    task automatic pop_level();
        open_scan(flags_t'(5'b00100));
        send_eof();
    endtask

    initial begin
        int start_depth;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: characters with no scan open, one at the top of the code point range.
        send_char(CH_LA);
        send_char(CH_TOP);
        // Recovering answers no token at once.
        open_scan(flags_t'(5'b10111));
        send_char(CH_LA);
        // INDENT, then NEWLINE at the same indent.
        open_scan(flags_t'(5'b00011));
        send_char(CH_LF);
        send_char(CH_SPACE);
        send_char(CH_UA);
        open_scan(flags_t'(5'b00001));
        send_char(CH_LF);
        send_char(CH_SPACE);
        send_char(CH_UZ);
        // A comment at the block's indent holds back the dedent.
        open_scan(flags_t'(5'b00101));
        send_char(CH_LF);
        send_char(CH_SPACE);
        send_char(CH_HASH);
        send_char(CH_LZ);
        send_char(CH_LF);
        send_char(CH_LZ);
        // DEDENT back to the base.
        open_scan(flags_t'(5'b00100));
        send_char(CH_LF);
        send_char(CH_LZ);
        // Trailing comment before any line break.
        open_scan(flags_t'(5'b00001));
        send_char(CH_HASH);
        // PATH on the slash, then a run cut off by end of file.
        open_scan(flags_t'(5'b01000));
        send_char(CH_LA);
        send_char(CH_DASH);
        send_char(CH_SLASH);
        open_scan(flags_t'(5'b01000));
        send_char(CH_DOT);
        send_eof();
        // End of file right at the opening decides with indent zero.
        open_scan(flags_t'(5'b00010));
        send_eof();
        wait_drained();

        // Fill the stack to the brim, refuse two more pushes, then pop back to the base.
        start_depth = sb.depth_cnt;
        repeat (STK_N - start_depth) push_level(1);
        repeat (2) push_level(1);
        repeat (STK_N - 1) pop_level();
        wait_drained();

        // Random phases; the first one also holds off the receiver for a long stretch
        // while requests keep coming, so the queue fills and the request side stalls.
        send_pct = 0;
        recv_pct = 0;
        random_traffic(30);
        hold_trigger++;
        random_traffic(60);
        wait_drained();

        send_pct = 53;
        recv_pct = 0;
        random_traffic(50);
        wait_drained();

        send_pct = 0;
        recv_pct = 53;
        random_traffic(50);
        wait_drained();

        send_pct = 25;
        recv_pct = 25;
        random_traffic(50);
        wait_drained();

        // Let any stray result surface before the verdict.
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== indent_dedent_token_scanner.f =====
rtl/core/idts_pkg.sv
rtl/core/idts_front.sv
rtl/core/idts_queue.sv
rtl/core/idts_back.sv
rtl/core/indent_dedent_token_scanner.sv
tb/indent_dedent_token_scanner_test.sv
